[hw/rtl/imubc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU bias calibration package
// Shared widths, register indexes and the structs passed between the lanes,
// the output merge stage and the top level.
// ----------------------------------------------------------------------------
package imubc_pkg;

  // Number of axes carried by one item: three gyro, then three accelerometer.
  localparam int AXES          = 6;
  localparam int GYRO_AXES     = 3;
  localparam int SAMPLE_W      = 16;
  localparam int CFG_W         = 16;
  localparam int ONE_G_W       = 15;
  // An average of 16-bit samples never exceeds 2^15 in magnitude, so the
  // serial divider only has to produce this many quotient bits.
  localparam int QUO_W         = 16;
  localparam int STEP_W        = $clog2(QUO_W);
  localparam int COUNT_BITS_DEF = 16;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]   CAL_COUNT_RST = 16'd1000;
  localparam logic [ONE_G_W-1:0] ONE_G_RST     = 15'd16384;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_CAL_COUNT = 1'b0,
    REG_ONE_G     = 1'b1
  } imubc_reg_t;

  // Input opcodes and result kinds.
  localparam logic OP_CALIBRATE = 1'b0;
  localparam logic OP_MEASURE   = 1'b1;
  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_BIAS    = 1'b1;

  // Six axis values, gyro x in the lowest bits.
  typedef logic [AXES-1:0][SAMPLE_W-1:0] imubc_axes_t;

  // One result item as held by the output stage.
  typedef struct packed {
    logic        kind;
    imubc_axes_t axes;
  } imubc_item_t;

  // Commands from the sequencer to every lane.
  typedef struct packed {
    logic acc;   // add the sample to the accumulator
    logic load;  // move the accumulator into the divider and clear it
    logic step;  // one restoring division step
    logic fin;   // apply the gravity step and store the bias
  } imubc_lane_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/imubc_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU bias lane
// One axis: signed accumulator, bit-serial divider for the average, gravity
// step, bias register and the subtraction that corrects a measurement.
// ----------------------------------------------------------------------------
module imubc_lane #(
  parameter int COUNT_BITS = imubc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire imubc_pkg::imubc_lane_ctl_t          ctl,
  input  wire logic signed [imubc_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [COUNT_BITS-1:0]               divisor,
  input  wire logic [imubc_pkg::ONE_G_W-1:0]       one_g,
  output logic [imubc_pkg::SAMPLE_W-1:0]           bias,
  output logic [imubc_pkg::SAMPLE_W-1:0]           corrected
);

  localparam int SW    = imubc_pkg::SAMPLE_W;
  localparam int QW    = imubc_pkg::QUO_W;
  localparam int SUM_W = SW + COUNT_BITS;

  logic signed [SUM_W-1:0]  sum_r,  sum_nxt;
  logic [COUNT_BITS-1:0]    rem_r,  rem_nxt;
  logic [QW-1:0]            shr_r,  shr_nxt;
  logic                     neg_r,  neg_nxt;
  logic [SW-1:0]            bias_r, bias_nxt;

  logic [SUM_W-1:0]         mag;
  logic [COUNT_BITS+1:0]    trial;
  logic [COUNT_BITS:0]      shifted;
  logic [QW:0]              quo_e;
  logic [QW:0]              g_e;
  logic [QW:0]              adj;
  logic [QW:0]              signed_adj;

  // Magnitude of the accumulated sum, taken when the divider is loaded.
  assign mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  // Restoring division step on the partial remainder.
  assign shifted = {rem_r, shr_r[QW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  // Gravity step: a magnitude of at least one g loses one g.
  assign quo_e      = {1'b0, shr_r};
  assign g_e        = {{(QW + 1 - imubc_pkg::ONE_G_W){1'b0}}, one_g};
  assign adj        = (quo_e >= g_e) ? (quo_e - g_e) : quo_e;
  assign signed_adj = neg_r ? (~adj + 1'b1) : adj;

  // Next-state logic for the accumulator and the divider.
  always_comb begin
    sum_nxt  = sum_r;
    rem_nxt  = rem_r;
    shr_nxt  = shr_r;
    neg_nxt  = neg_r;
    bias_nxt = bias_r;
    if (ctl.acc) begin
      sum_nxt = sum_r + SUM_W'(sample);
    end
    if (ctl.load) begin
      rem_nxt = mag[SUM_W-1:QW];
      shr_nxt = mag[QW-1:0];
      neg_nxt = sum_r[SUM_W-1];
      sum_nxt = '0;
    end
    if (ctl.step) begin
      if (!trial[COUNT_BITS+1]) begin
        rem_nxt = trial[COUNT_BITS-1:0];
        shr_nxt = {shr_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[COUNT_BITS-1:0];
        shr_nxt = {shr_r[QW-2:0], 1'b0};
      end
    end
    if (ctl.fin) begin
      bias_nxt = signed_adj[SW-1:0];
    end
  end

  // Accumulator and bias are architectural state; the divider is scratch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      bias_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      bias_r <= bias_nxt;
    end
    rem_r <= rem_nxt;
    shr_r <= shr_nxt;
    neg_r <= neg_nxt;
  end

  assign bias      = bias_r;
  assign corrected = SW'(sample - $signed(bias_r));

endmodule

`default_nettype wire

[hw/rtl/imubc_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU result merge stage
// Gathers the six lane values into one result item and holds it in an output
// register backed by a spare slot, so the input side keeps moving while a
// result waits.
// ----------------------------------------------------------------------------
module imubc_merge (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic                   push_kind,
  input  wire imubc_pkg::imubc_axes_t push_axes,
  output logic                        full,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [95:0]                 out_tdata,  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  output logic [0:0]                  out_tuser   // result_kind
);

  imubc_pkg::imubc_item_t item;
  imubc_pkg::imubc_item_t out_r,  out_nxt;
  imubc_pkg::imubc_item_t pend_r, pend_nxt;
  logic                   out_vld_r,  out_vld_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic                   out_free;

  assign item.kind = push_kind;
  assign item.axes = push_axes;

  // The output register frees when empty or when its transfer completes.
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    if (out_free) begin
      if (pend_vld_r) begin
        out_nxt      = pend_r;
        out_vld_nxt  = 1'b1;
        pend_nxt     = item;
        pend_vld_nxt = push;
      end else begin
        out_nxt     = item;
        out_vld_nxt = push;
      end
    end else if (push) begin
      pend_nxt     = item;
      pend_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign full       = pend_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.axes;
  assign out_tuser  = out_r.kind;

endmodule

`default_nettype wire

[hw/rtl/imu_bias_calibrate_correct.sv]
// A measurement transfer's result is registered in the merge stage; a
// calibration transfer yields nothing until the sample count is reached.
// Throughput: one measurement per cycle while results are taken; the final
// calibration transfer holds in_tready low through the load, the 16 steps of
// the lanes' serial dividers, the gravity step and the emit, before the biases appear.
// Synchronous active-low reset clears sums, count and biases; loads 1000 and 16384.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU bias calibration and correction
// Six parallel axis lanes accumulate calibration samples, divide to find the
// biases and correct measurement samples; a merge stage forms the results.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_correct #(
  parameter int COUNT_BITS = imubc_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  input  wire logic [0:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // out_gyro_x .. out_accel_z
  output logic [0:0]       out_tuser,  // result_kind
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int CFG_W = imubc_pkg::CFG_W;
  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int STW   = imubc_pkg::STEP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  state_t                             state_r;
  logic [CFG_W-1:0]                   cal_count_r;
  logic [imubc_pkg::ONE_G_W-1:0]      one_g_r;
  logic [COUNT_BITS-1:0]              samples_r;
  logic [COUNT_BITS-1:0]              divisor_r;
  logic [STW-1:0]                     step_r;

  imubc_pkg::imubc_axes_t             in_axes;
  imubc_pkg::imubc_axes_t             bias_axes;
  imubc_pkg::imubc_axes_t             corr_axes;
  imubc_pkg::imubc_lane_ctl_t         ctl;
  logic                               accept;
  logic                               accept_cal;
  logic                               accept_meas;
  logic [COUNT_BITS-1:0]              taken;
  logic                               cal_done;
  logic                               merge_full;
  logic                               push;
  logic                               push_kind;
  imubc_pkg::imubc_axes_t             push_axes;

  assign in_axes     = in_tdata;
  assign in_tready   = (state_r == ST_IDLE) && !merge_full;
  assign accept      = in_tvalid && in_tready;
  assign accept_cal  = accept && (in_tuser[0] == imubc_pkg::OP_CALIBRATE);
  assign accept_meas = accept && (in_tuser[0] == imubc_pkg::OP_MEASURE);

  // The calibration ends once the new count reaches the target, where the
  // target is the register value raised to at least one and capped at the
  // counter's full scale.
  assign taken    = COUNT_BITS'(samples_r + 1'b1);
  assign cal_done = (taken != '0) &&
                    ((CMP_W'(taken) >= CMP_W'(cal_count_r)) || (&taken));

  // Lane commands follow the sequencer state.
  assign ctl.acc  = accept_cal;
  assign ctl.load = (state_r == ST_LOAD);
  assign ctl.step = (state_r == ST_DIV);
  assign ctl.fin  = (state_r == ST_FIN);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_count_r <= imubc_pkg::CAL_COUNT_RST;
      one_g_r     <= imubc_pkg::ONE_G_RST;
    end else if (cfg_we) begin
      unique case (imubc_pkg::imubc_reg_t'(cfg_addr))
        imubc_pkg::REG_CAL_COUNT: cal_count_r <= cfg_wdata;
        imubc_pkg::REG_ONE_G:     one_g_r     <= cfg_wdata[imubc_pkg::ONE_G_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: sample count, divisor capture and division steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      samples_r <= '0;
      step_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept_cal) begin
            if (cal_done) begin
              samples_r <= '0;
              state_r   <= ST_LOAD;
            end else begin
              samples_r <= taken;
            end
          end
        end
        ST_LOAD: begin
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == STW'(imubc_pkg::QUO_W - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    if (accept_cal && cal_done) begin
      divisor_r <= taken;
    end
  end

  // Axis lanes; only the accelerometer lanes see the one g step.
  for (genvar i = 0; i < imubc_pkg::AXES; i++) begin : g_lane
    logic [imubc_pkg::ONE_G_W-1:0] lane_g;
    assign lane_g = (i >= imubc_pkg::GYRO_AXES) ? one_g_r : '0;

    imubc_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sample   (in_axes[i]),
      .divisor  (divisor_r),
      .one_g    (lane_g),
      .bias     (bias_axes[i]),
      .corrected(corr_axes[i])
    );
  end

  // A measurement pushes its corrected values; the end of a calibration
  // pushes the new biases.
  assign push      = accept_meas || (state_r == ST_EMIT);
  assign push_kind = (state_r == ST_EMIT) ? imubc_pkg::KIND_BIAS : imubc_pkg::KIND_MEASURE;
  assign push_axes = (state_r == ST_EMIT) ? bias_axes : corr_axes;

  imubc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_kind (push_kind),
    .push_axes (push_axes),
    .full      (merge_full),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/imubc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU bias calibration port checker
// Watches the top-level ports for output stability, reset behaviour, the
// one-result-per-measurement rule and the input stall before a bias result.
// ----------------------------------------------------------------------------
module imubc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // A measurement transfer always leaves a result waiting on the next cycle.
  a_meas_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == imubc_pkg::OP_MEASURE) |=> out_tvalid)
    else $error("measurement produced no result");

  // A new bias result only appears while the input is held off.
  a_bias_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && (out_tuser[0] == imubc_pkg::KIND_BIAS) |-> $past(!in_tready))
    else $error("bias result without a calibration stall");

endmodule

bind imu_bias_calibrate_correct imubc_checker u_imubc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire

[verif/tb_imu_bias_calibrate_correct.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IMU bias calibration and correction block
// Drives calibration and measurement samples with random gaps and output
// stalls, predicts every bias set and corrected sample, and checks each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_imu_bias_calibrate_correct;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 9;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 25;
  localparam int LONG_HOLD       = 300;
  localparam int RANDOM_PHASES   = 13;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int MAX_PRINTED     = 40;

  // Tracks the block's sums, sample count and biases, and queues the results
  // that each accepted sample should produce.
  class bias_scoreboard;
    logic [15:0]            cal_count = imubc_pkg::CAL_COUNT_RST;
    logic [14:0]            one_g     = imubc_pkg::ONE_G_RST;
    longint                 sums [imubc_pkg::AXES];
    logic [15:0]            taken     = '0;
    imubc_pkg::imubc_axes_t bias      = '0;
    imubc_pkg::imubc_item_t due [$];
    int unsigned            errors    = 0;
    string                  axis_name [imubc_pkg::AXES] = '{"gyro_x", "gyro_y", "gyro_z",
                                                           "accel_x", "accel_y", "accel_z"};

    function void flag(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endfunction

    function void write_reg(imubc_pkg::imubc_reg_t idx, logic [15:0] val);
      case (idx)
        imubc_pkg::REG_CAL_COUNT: cal_count = val;
        imubc_pkg::REG_ONE_G:     one_g     = val[14:0];
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Note one accepted input transfer.
    function void note_input(logic op, imubc_pkg::imubc_axes_t s);
      imubc_pkg::imubc_item_t r;
      int                     target;
      int                     q;
      int                     mag;
      int                     i;
      if (op == imubc_pkg::OP_MEASURE) begin
        r.kind = imubc_pkg::KIND_MEASURE;
        for (i = 0; i < imubc_pkg::AXES; i++) r.axes[i] = s[i] - bias[i];
        due.push_back(r);
        return;
      end
      // A zero count behaves as a count of one.
      target = (cal_count == 0) ? 1 : int'(cal_count);
      for (i = 0; i < imubc_pkg::AXES; i++) sums[i] += longint'($signed(s[i]));
      taken = taken + 16'd1;
      if (int'(taken) < target) return;
      // Average with truncation toward zero; accelerometer biases of at
      // least one g are moved one g toward zero so that gravity remains.
      for (i = 0; i < imubc_pkg::AXES; i++) begin
        q = int'(sums[i] / longint'(taken));
        if (i >= imubc_pkg::GYRO_AXES) begin
          mag = (q < 0) ? -q : q;
          if (mag >= int'(one_g)) q = (q > 0) ? q - int'(one_g) : q + int'(one_g);
        end
        bias[i] = q[15:0];
        sums[i] = 0;
      end
      taken  = '0;
      r.kind = imubc_pkg::KIND_BIAS;
      r.axes = bias;
      due.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(logic kind, imubc_pkg::imubc_axes_t got);
      imubc_pkg::imubc_item_t want;
      int                     i;
      if (due.size() == 0) begin
        flag($sformatf("unexpected result, kind %0b", kind));
        return;
      end
      want = due.pop_front();
      if (kind !== want.kind)
        flag($sformatf("result_kind: got %0b, expected %0b", kind, want.kind));
      for (i = 0; i < imubc_pkg::AXES; i++)
        if (got[i] !== want.axes[i])
          flag($sformatf("%s: got %04h, expected %04h", axis_name[i], got[i],
                         want.axes[i]));
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [95:0] in_tdata  = '0;   // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  logic [0:0]  in_tuser  = '0;   // opcode
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [95:0] out_tdata;        // out_gyro_x .. out_accel_z
  wire  [0:0]  out_tuser;        // result_kind
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_addr  = '0;
  logic [15:0] cfg_wdata = '0;

  bias_scoreboard sb = new();
  int             cycle_count = 0;
  bit             steady = 1'b0;        // no idling on either side
  bit             hold_request = 1'b0;  // asks the receiver for a long hold-off
  logic [15:0]    centre [imubc_pkg::AXES];  // typical sample of the current phase

  imu_bias_calibrate_correct uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Observe both channels at every edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser[0], imubc_pkg::imubc_axes_t'(in_tdata));
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser[0], imubc_pkg::imubc_axes_t'(out_tdata));
    end
  end

  // Idle length: mostly short, now and then long.
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 50);
  endfunction

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin : sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        stall = idle_len() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic imubc_pkg::imubc_axes_t all_axes(logic [15:0] v);
    imubc_pkg::imubc_axes_t s;
    int                     i;
    for (i = 0; i < imubc_pkg::AXES; i++) s[i] = v;
    return s;
  endfunction

  function automatic imubc_pkg::imubc_axes_t six(logic [15:0] gx, logic [15:0] gy,
                                                 logic [15:0] gz, logic [15:0] ax,
                                                 logic [15:0] ay, logic [15:0] az);
    imubc_pkg::imubc_axes_t s;
    s[0] = gx; s[1] = gy; s[2] = gz;
    s[3] = ax; s[4] = ay; s[5] = az;
    return s;
  endfunction

  // Choose the typical sample for a phase; accelerometer axes sit close to
  // plus or minus one g in half the cases, so the gravity step is hit from both sides.
  function automatic void pick_centre();
    int i;
    int g;
    g = int'(sb.one_g);
    for (i = 0; i < imubc_pkg::AXES; i++) begin
      if (i < imubc_pkg::GYRO_AXES)
        centre[i] = ($urandom_range(0, 1) == 0) ? 16'(int'($urandom_range(0, 400)) - 200)
                                                : 16'($urandom);
      else
        case ($urandom_range(0, 3))
          0:       centre[i] = 16'(g + int'($urandom_range(0, 12)) - 6);
          1:       centre[i] = 16'(-g + int'($urandom_range(0, 12)) - 6);
          2:       centre[i] = 16'($urandom);
          default: centre[i] = 16'(int'($urandom_range(0, 20)) - 10);
        endcase
    end
  endfunction

  // Sample near the phase centre, fully random, or one of 8000h, 7FFFh, 0000h and FFFFh.
  function automatic imubc_pkg::imubc_axes_t pick_sample();
    imubc_pkg::imubc_axes_t s;
    int                     mode;
    int                     noise;
    int                     i;
    mode = $urandom_range(0, 99);
    for (i = 0; i < imubc_pkg::AXES; i++) begin
      noise = int'($urandom_range(0, 14)) - 7;
      if (mode < 60)
        s[i] = 16'(int'($signed(centre[i])) + noise);
      else if (mode < 85)
        s[i] = 16'($urandom);
      else
        case ($urandom_range(0, 3))
          0:       s[i] = 16'h8000;
          1:       s[i] = 16'h7FFF;
          2:       s[i] = 16'h0000;
          default: s[i] = 16'hFFFF;
        endcase
    end
    return s;
  endfunction

  // Offer one input item and wait for its transfer.
  task automatic send_item(logic op, imubc_pkg::imubc_axes_t s);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 65) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending, wait for every predicted result, then let the block sit idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes, only while the block is idle.
  task automatic set_regs(bit wr_count, logic [15:0] count, bit wr_g, logic [15:0] g);
    if (wr_count) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= imubc_pkg::REG_CAL_COUNT;
      cfg_wdata <= count;
      @(posedge clk);
      sb.write_reg(imubc_pkg::REG_CAL_COUNT, count);
    end
    if (wr_g) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= imubc_pkg::REG_ONE_G;
      cfg_wdata <= g;
      @(posedge clk);
      sb.write_reg(imubc_pkg::REG_ONE_G, g);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int          ph;
    int          n;
    int          r;
    logic [15:0] count;
    logic [15:0] g;
    bit          wr_c;
    bit          wr_g;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);
    pick_centre();

    // Measurements before any calibration use zero biases; a few
    // calibration samples start a long average at the reset count.
    send_item(imubc_pkg::OP_MEASURE, all_axes(16'h7FFF));
    send_item(imubc_pkg::OP_MEASURE, all_axes(16'h8000));
    repeat (3) send_item(imubc_pkg::OP_CALIBRATE, pick_sample());
    settle();

    // A zero count acts as one: the partial average completes at once,
    // then single-sample averages at the extremes with a one-count g.
    set_regs(1'b1, 16'd0, 1'b1, 16'd1);
    send_item(imubc_pkg::OP_CALIBRATE, all_axes(16'h8000));
    send_item(imubc_pkg::OP_CALIBRATE, all_axes(16'h8000));
    send_item(imubc_pkg::OP_MEASURE, all_axes(16'h7FFF));
    send_item(imubc_pkg::OP_MEASURE, all_axes(16'h8000));
    send_item(imubc_pkg::OP_CALIBRATE, all_axes(16'h7FFF));
    send_item(imubc_pkg::OP_MEASURE, all_axes(16'h8000));
    settle();

    // With one g at zero the gravity step leaves every bias alone.
    set_regs(1'b1, 16'd1, 1'b1, 16'd0);
    send_item(imubc_pkg::OP_CALIBRATE,
              six(16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000));
    send_item(imubc_pkg::OP_MEASURE, all_axes(16'h0000));
    settle();

    // Odd sums truncate toward zero; biases of exactly one g go to zero.
    set_regs(1'b1, 16'd2, 1'b1, 16'h7FFF);
    send_item(imubc_pkg::OP_CALIBRATE,
              six(16'h0003, 16'hFFFC, 16'h0005, 16'h7FFF, 16'h8001, 16'h7FFE));
    send_item(imubc_pkg::OP_CALIBRATE,
              six(16'hFFFE, 16'hFFFD, 16'h0000, 16'h7FFF, 16'h8001, 16'h7FFE));
    send_item(imubc_pkg::OP_MEASURE, pick_sample());
    settle();

    // Largest count, then lowered mid-average: the next sample completes it.
    // The top bit of the one g write is not stored.
    set_regs(1'b1, 16'hFFFF, 1'b1, 16'hC000);
    repeat (2) send_item(imubc_pkg::OP_CALIBRATE, pick_sample());
    settle();
    set_regs(1'b1, 16'd3, 1'b0, 16'd0);
    send_item(imubc_pkg::OP_CALIBRATE, pick_sample());
    send_item(imubc_pkg::OP_MEASURE, pick_sample());
    settle();

    // Random phases, each with its own settings and sample centre.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      r = $urandom_range(0, 99);
      if (r < 5)       count = 16'd0;
      else if (r < 45) count = 16'($urandom_range(1, 4));
      else if (r < 85) count = 16'($urandom_range(5, 20));
      else             count = 16'($urandom_range(21, 60));
      case ($urandom_range(0, 7))
        0:       g = 16'd16384;
        1:       g = 16'd8192;
        2:       g = 16'd4096;
        3:       g = 16'd2048;
        4:       g = 16'd0;
        5:       g = 16'd1;
        6:       g = 16'd32767;
        default: g = 16'($urandom_range(1, 32767));
      endcase
      if ($urandom_range(0, 99) < 15) g = g | 16'h8000;
      wr_c = ($urandom_range(0, 99) < 70);
      wr_g = ($urandom_range(0, 99) < 70);
      set_regs(wr_c, count, wr_g, g);
      pick_centre();
      steady = (ph % 4 == 2);

      // Receiver holds off for a long stretch while samples keep coming.
      if (ph == 5) begin
        steady = 1'b1;
        hold_request = 1'b1;
      end

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Sender pauses until every result has come back.
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) settle();
        if ($urandom_range(0, 99) < 3) pick_centre();
        if ($urandom_range(0, 99) < 55) send_item(imubc_pkg::OP_CALIBRATE, pick_sample());
        else                            send_item(imubc_pkg::OP_MEASURE, pick_sample());
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
